@@ src/akf_pkg.sv @@
// Shared types, constants and arithmetic helpers for the angle Kalman filter.
`timescale 1ns / 1ps
package akf_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam logic [31:0] FullTurn = 32'd23592960;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;
  localparam logic signed [31:0] IntMax = 32'sh7fffffff;
  localparam logic signed [31:0] IntMin = 32'sh80000000;

  localparam logic [CfgIdxW-1:0] RegAngleNoise = 8'd0;
  localparam logic [CfgIdxW-1:0] RegBiasNoise = 8'd1;
  localparam logic [CfgIdxW-1:0] RegMeasNoise = 8'd2;
  localparam logic [CfgIdxW-1:0] RegPeriod = 8'd3;

  typedef struct packed {
    logic signed [31:0] accel_angle;
    logic signed [31:0] gyro_rate;
  } in_item_t;

  typedef struct packed {
    logic [24:0] fused_angle;
    logic signed [31:0] fused_rate;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_PDOT,
    OP_M_ANG,
    OP_A_ANG,
    OP_M_C00,
    OP_A_C00,
    OP_M_C01,
    OP_A_C01,
    OP_M_C11,
    OP_A_C11,
    OP_ERR,
    OP_DIV_LD0,
    OP_DIV_LD1,
    OP_DIV_STEP,
    OP_DIV_WR0,
    OP_DIV_WR1,
    OP_M_C10U,
    OP_A_C10U,
    OP_M_C11U,
    OP_A_C11U,
    OP_M_C00U,
    OP_A_C00U,
    OP_M_C01U,
    OP_A_C01U,
    OP_M_ANGU,
    OP_A_ANGU,
    OP_M_BIAS,
    OP_A_BIAS,
    OP_RATE,
    OP_WRAP_LD,
    OP_WRAP_STEP
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PDOT,
    ST_M_ANG,
    ST_A_ANG,
    ST_M_C00,
    ST_A_C00,
    ST_M_C01,
    ST_A_C01,
    ST_M_C11,
    ST_A_C11,
    ST_ERR,
    ST_DIV_LD0,
    ST_DIV_RUN0,
    ST_DIV_LD1,
    ST_DIV_RUN1,
    ST_M_C10U,
    ST_A_C10U,
    ST_M_C11U,
    ST_A_C11U,
    ST_M_C00U,
    ST_A_C00U,
    ST_M_C01U,
    ST_A_C01U,
    ST_M_ANGU,
    ST_A_ANGU,
    ST_M_BIAS,
    ST_A_BIAS,
    ST_RATE,
    ST_WRAP_LD,
    ST_WRAP_RUN,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic wrap_busy;
    logic out_blocked;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) r = IntMax;
    else if (v < -38'sd2147483648) r = IntMin;
    else r = v[31:0];
    return r;
  endfunction

  // base plus or minus a 36-bit term such as a rounded product, saturated
  function automatic logic signed [31:0] acc_sat(input logic signed [31:0] b,
                                                 input logic signed [35:0] d,
                                                 input logic sub);
    logic signed [37:0] s;
    if (sub) s = 38'(b) - 38'(d);
    else s = 38'(b) + 38'(d);
    return sat32(s);
  endfunction

  // unsigned Q0.32 to Q1.30, rounded
  function automatic logic [30:0] to_q30(input logic [31:0] q);
    logic [32:0] s;
    s = {1'b0, q} + 33'd2;
    return s[32:2];
  endfunction

endpackage

@@ src/akf_ctrl.sv @@
// Sequencing state machine of the angle Kalman filter.
`timescale 1ns / 1ps
module akf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  akf_pkg::status_t status_i,
  output akf_pkg::cmd_t    cmd_o
);

  akf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= akf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o.op = akf_pkg::OP_NOP;
    cmd_o.out_load = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      akf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = akf_pkg::OP_LATCH;
          state_d = akf_pkg::ST_PDOT;
        end
      end
      akf_pkg::ST_PDOT: begin
        cmd_o.op = akf_pkg::OP_PDOT;
        state_d = akf_pkg::ST_M_ANG;
      end
      akf_pkg::ST_M_ANG: begin
        cmd_o.op = akf_pkg::OP_M_ANG;
        state_d = akf_pkg::ST_A_ANG;
      end
      akf_pkg::ST_A_ANG: begin
        cmd_o.op = akf_pkg::OP_A_ANG;
        state_d = akf_pkg::ST_M_C00;
      end
      akf_pkg::ST_M_C00: begin
        cmd_o.op = akf_pkg::OP_M_C00;
        state_d = akf_pkg::ST_A_C00;
      end
      akf_pkg::ST_A_C00: begin
        cmd_o.op = akf_pkg::OP_A_C00;
        state_d = akf_pkg::ST_M_C01;
      end
      akf_pkg::ST_M_C01: begin
        cmd_o.op = akf_pkg::OP_M_C01;
        state_d = akf_pkg::ST_A_C01;
      end
      akf_pkg::ST_A_C01: begin
        cmd_o.op = akf_pkg::OP_A_C01;
        state_d = akf_pkg::ST_M_C11;
      end
      akf_pkg::ST_M_C11: begin
        cmd_o.op = akf_pkg::OP_M_C11;
        state_d = akf_pkg::ST_A_C11;
      end
      akf_pkg::ST_A_C11: begin
        cmd_o.op = akf_pkg::OP_A_C11;
        state_d = akf_pkg::ST_ERR;
      end
      akf_pkg::ST_ERR: begin
        cmd_o.op = akf_pkg::OP_ERR;
        state_d = akf_pkg::ST_DIV_LD0;
      end
      akf_pkg::ST_DIV_LD0: begin
        cmd_o.op = akf_pkg::OP_DIV_LD0;
        state_d = akf_pkg::ST_DIV_RUN0;
      end
      akf_pkg::ST_DIV_RUN0: begin
        if (status_i.div_busy) begin
          cmd_o.op = akf_pkg::OP_DIV_STEP;
        end else begin
          cmd_o.op = akf_pkg::OP_DIV_WR0;
          state_d = akf_pkg::ST_DIV_LD1;
        end
      end
      akf_pkg::ST_DIV_LD1: begin
        cmd_o.op = akf_pkg::OP_DIV_LD1;
        state_d = akf_pkg::ST_DIV_RUN1;
      end
      akf_pkg::ST_DIV_RUN1: begin
        if (status_i.div_busy) begin
          cmd_o.op = akf_pkg::OP_DIV_STEP;
        end else begin
          cmd_o.op = akf_pkg::OP_DIV_WR1;
          state_d = akf_pkg::ST_M_C10U;
        end
      end
      // p00 is read by the cov_10 update, so cov_00 goes after it
      akf_pkg::ST_M_C10U: begin
        cmd_o.op = akf_pkg::OP_M_C10U;
        state_d = akf_pkg::ST_A_C10U;
      end
      akf_pkg::ST_A_C10U: begin
        cmd_o.op = akf_pkg::OP_A_C10U;
        state_d = akf_pkg::ST_M_C11U;
      end
      akf_pkg::ST_M_C11U: begin
        cmd_o.op = akf_pkg::OP_M_C11U;
        state_d = akf_pkg::ST_A_C11U;
      end
      akf_pkg::ST_A_C11U: begin
        cmd_o.op = akf_pkg::OP_A_C11U;
        state_d = akf_pkg::ST_M_C00U;
      end
      akf_pkg::ST_M_C00U: begin
        cmd_o.op = akf_pkg::OP_M_C00U;
        state_d = akf_pkg::ST_A_C00U;
      end
      akf_pkg::ST_A_C00U: begin
        cmd_o.op = akf_pkg::OP_A_C00U;
        state_d = akf_pkg::ST_M_C01U;
      end
      akf_pkg::ST_M_C01U: begin
        cmd_o.op = akf_pkg::OP_M_C01U;
        state_d = akf_pkg::ST_A_C01U;
      end
      akf_pkg::ST_A_C01U: begin
        cmd_o.op = akf_pkg::OP_A_C01U;
        state_d = akf_pkg::ST_M_ANGU;
      end
      akf_pkg::ST_M_ANGU: begin
        cmd_o.op = akf_pkg::OP_M_ANGU;
        state_d = akf_pkg::ST_A_ANGU;
      end
      akf_pkg::ST_A_ANGU: begin
        cmd_o.op = akf_pkg::OP_A_ANGU;
        state_d = akf_pkg::ST_M_BIAS;
      end
      akf_pkg::ST_M_BIAS: begin
        cmd_o.op = akf_pkg::OP_M_BIAS;
        state_d = akf_pkg::ST_A_BIAS;
      end
      akf_pkg::ST_A_BIAS: begin
        cmd_o.op = akf_pkg::OP_A_BIAS;
        state_d = akf_pkg::ST_RATE;
      end
      akf_pkg::ST_RATE: begin
        cmd_o.op = akf_pkg::OP_RATE;
        state_d = akf_pkg::ST_WRAP_LD;
      end
      akf_pkg::ST_WRAP_LD: begin
        cmd_o.op = akf_pkg::OP_WRAP_LD;
        state_d = akf_pkg::ST_WRAP_RUN;
      end
      akf_pkg::ST_WRAP_RUN: begin
        if (status_i.wrap_busy) begin
          cmd_o.op = akf_pkg::OP_WRAP_STEP;
        end else begin
          state_d = akf_pkg::ST_OUT;
        end
      end
      akf_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!status_i.out_blocked) begin
          cmd_o.out_load = 1'b1;
          state_d = akf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = akf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/akf_datapath.sv @@
// Datapath: filter state, shared multiplier, divider, angle wrap and output register.
`timescale 1ns / 1ps
module akf_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  akf_pkg::cmd_t                 cmd_i,
  output akf_pkg::status_t              status_o,
  input  akf_pkg::in_item_t             in_data_i,
  input  logic                          cfg_we_i,
  input  logic [akf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output akf_pkg::out_item_t            out_data_o
);

  logic [31:0] apn_q, bpn_q, mn_q, dt_q;
  logic signed [31:0] ang_q, bias_q, c00_q, c01_q, c10_q, c11_q;
  logic signed [31:0] accel_q, gyro_q, rate_q, pd0_q, pd1_q, pd3_q, err_q, k0_q, k1_q;
  logic signed [33:0] e_q;
  logic signed [65:0] prod_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_rnd32, prod_rnd30;
  logic signed [35:0] r32, r30;

  // divider
  logic [4:0]  div_cnt_q;
  logic [32:0] div_r_q;
  logic [30:0] div_q_q;
  logic        div_neg_q, div_sat_q, div_bit0_q;
  logic [31:0] div_abs;
  logic signed [31:0] div_num;
  logic [33:0] div_r2;
  logic [33:0] div_e;
  logic        div_ge;
  logic        e_pos;
  logic signed [31:0] k_res;

  // angle wrap
  logic [2:0]  wr_cnt_q;
  logic [31:0] wr_x_q;
  logic        wr_above_q, wr_neg_q;
  logic [31:0] wr_sub;
  logic signed [31:0] wr_res;

  logic out_valid_q;
  akf_pkg::out_item_t out_q;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      akf_pkg::OP_M_ANG: begin
        mul_a = 33'(rate_q);
        mul_b = {1'b0, dt_q};
      end
      akf_pkg::OP_M_C00: begin
        mul_a = 33'(pd0_q);
        mul_b = {1'b0, dt_q};
      end
      akf_pkg::OP_M_C01: begin
        mul_a = 33'(pd1_q);
        mul_b = {1'b0, dt_q};
      end
      akf_pkg::OP_M_C11: begin
        mul_a = 33'(pd3_q);
        mul_b = {1'b0, dt_q};
      end
      akf_pkg::OP_M_C10U: begin
        mul_a = 33'(k1_q);
        mul_b = 33'(c00_q);
      end
      akf_pkg::OP_M_C11U: begin
        mul_a = 33'(k1_q);
        mul_b = 33'(c01_q);
      end
      akf_pkg::OP_M_C00U: begin
        mul_a = 33'(k0_q);
        mul_b = 33'(c00_q);
      end
      akf_pkg::OP_M_C01U: begin
        mul_a = 33'(k0_q);
        mul_b = 33'(c01_q);
      end
      akf_pkg::OP_M_ANGU: begin
        mul_a = 33'(k0_q);
        mul_b = 33'(err_q);
      end
      akf_pkg::OP_M_BIAS: begin
        mul_a = 33'(k1_q);
        mul_b = 33'(err_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_rnd32 = (prod_q + 66'sd2147483648) >>> 32;
  assign prod_rnd30 = (prod_q + 66'sd536870912) >>> 30;
  assign r32 = prod_rnd32[35:0];
  assign r30 = prod_rnd30[35:0];

  assign div_num = (cmd_i.op == akf_pkg::OP_DIV_LD1) ? c10_q : c00_q;
  assign div_abs = div_num[31] ? 32'(-div_num) : 32'(div_num);
  assign div_e = e_q;
  assign div_r2 = {div_r_q, ((div_cnt_q == 5'd31) ? div_bit0_q : 1'b0)};
  assign div_ge = div_r2 >= div_e;
  assign e_pos = !e_q[33] && (e_q != '0);

  always_comb begin
    if (!e_pos) k_res = '0;
    else if (div_sat_q) k_res = div_neg_q ? akf_pkg::IntMin : akf_pkg::IntMax;
    else if (div_neg_q) k_res = -$signed({1'b0, div_q_q});
    else k_res = $signed({1'b0, div_q_q});
  end

  assign wr_sub = akf_pkg::FullTurn << (wr_cnt_q - 3'd1);

  always_comb begin
    if (wr_above_q) wr_res = $signed(wr_x_q + 32'd1);
    else if (wr_neg_q) wr_res = (wr_x_q == '0) ? '0 : $signed(akf_pkg::FullTurn - wr_x_q);
    else wr_res = ang_q;
  end

  assign status_o.div_busy = div_cnt_q != '0;
  assign status_o.wrap_busy = wr_cnt_q != '0;
  assign status_o.out_blocked = out_valid_q && out_stall_i;

  // configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apn_q <= 32'd4294967;
      bpn_q <= 32'd12884902;
      mn_q <= 32'd2147483648;
      dt_q <= 32'd21474836;
      ang_q <= '0;
      bias_q <= '0;
      c00_q <= akf_pkg::OneQ30;
      c01_q <= '0;
      c10_q <= '0;
      c11_q <= akf_pkg::OneQ30;
      div_cnt_q <= '0;
      wr_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          akf_pkg::RegAngleNoise: apn_q <= cfg_data_i;
          akf_pkg::RegBiasNoise: bpn_q <= cfg_data_i;
          akf_pkg::RegMeasNoise: mn_q <= cfg_data_i;
          akf_pkg::RegPeriod: dt_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        akf_pkg::OP_A_ANG: ang_q <= akf_pkg::acc_sat(ang_q, r32, 1'b0);
        akf_pkg::OP_A_C00: c00_q <= akf_pkg::acc_sat(c00_q, r32, 1'b0);
        akf_pkg::OP_A_C01: begin
          c01_q <= akf_pkg::acc_sat(c01_q, r32, 1'b0);
          c10_q <= akf_pkg::acc_sat(c10_q, r32, 1'b0);
        end
        akf_pkg::OP_A_C11: c11_q <= akf_pkg::acc_sat(c11_q, r32, 1'b0);
        akf_pkg::OP_A_C10U: c10_q <= akf_pkg::acc_sat(c10_q, r30, 1'b1);
        akf_pkg::OP_A_C11U: c11_q <= akf_pkg::acc_sat(c11_q, r30, 1'b1);
        akf_pkg::OP_A_C00U: c00_q <= akf_pkg::acc_sat(c00_q, r30, 1'b1);
        akf_pkg::OP_A_C01U: c01_q <= akf_pkg::acc_sat(c01_q, r30, 1'b1);
        akf_pkg::OP_A_ANGU: ang_q <= akf_pkg::acc_sat(ang_q, r30, 1'b0);
        akf_pkg::OP_A_BIAS: bias_q <= akf_pkg::acc_sat(bias_q, r30, 1'b0);
        akf_pkg::OP_DIV_LD0, akf_pkg::OP_DIV_LD1: div_cnt_q <= 5'd31;
        akf_pkg::OP_DIV_STEP: div_cnt_q <= div_cnt_q - 5'd1;
        akf_pkg::OP_WRAP_LD: wr_cnt_q <= 3'd7;
        akf_pkg::OP_WRAP_STEP: wr_cnt_q <= wr_cnt_q - 3'd1;
        default: ;
      endcase
      if (cmd_i.out_load) begin
        ang_q <= wr_res;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      akf_pkg::OP_LATCH: begin
        accel_q <= in_data_i.accel_angle;
        gyro_q <= in_data_i.gyro_rate;
      end
      akf_pkg::OP_PDOT: begin
        rate_q <= akf_pkg::acc_sat(gyro_q, 36'(bias_q), 1'b1);
        pd0_q <= akf_pkg::sat32(38'({1'b0, akf_pkg::to_q30(apn_q)}) - 38'(c01_q)
                                - 38'(c10_q));
        pd1_q <= akf_pkg::sat32(-38'(c11_q));
        pd3_q <= $signed({1'b0, akf_pkg::to_q30(bpn_q)});
      end
      akf_pkg::OP_ERR: begin
        err_q <= akf_pkg::acc_sat(accel_q, 36'(ang_q), 1'b1);
        e_q <= 34'({1'b0, akf_pkg::to_q30(mn_q)}) + 34'(c00_q);
      end
      akf_pkg::OP_DIV_LD0, akf_pkg::OP_DIV_LD1: begin
        div_neg_q <= div_num[31];
        div_sat_q <= 35'(div_abs) >= {div_e, 1'b0};
        div_r_q <= 33'(div_abs[31:1]);
        div_bit0_q <= div_abs[0];
        div_q_q <= '0;
      end
      akf_pkg::OP_DIV_STEP: begin
        div_r_q <= div_ge ? 33'(div_r2 - div_e) : div_r2[32:0];
        div_q_q <= {div_q_q[29:0], div_ge};
      end
      akf_pkg::OP_DIV_WR0: k0_q <= k_res;
      akf_pkg::OP_DIV_WR1: k1_q <= k_res;
      akf_pkg::OP_RATE: rate_q <= akf_pkg::acc_sat(gyro_q, 36'(bias_q), 1'b1);
      akf_pkg::OP_WRAP_LD: begin
        wr_above_q <= ang_q > $signed(akf_pkg::FullTurn);
        wr_neg_q <= ang_q[31];
        if (ang_q > $signed(akf_pkg::FullTurn)) wr_x_q <= 32'(ang_q - 32'sd1);
        else wr_x_q <= 32'(-ang_q);
      end
      akf_pkg::OP_WRAP_STEP: begin
        if (wr_x_q >= wr_sub) wr_x_q <= wr_x_q - wr_sub;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_q.fused_angle <= wr_res[24:0];
      out_q.fused_rate <= rate_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_cnt_q != '0) |=> (div_cnt_q == $past(div_cnt_q) - 5'd1))
    else $error("divider count did not advance");

  a_wrap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_cnt_q != '0) |=> (wr_cnt_q == $past(wr_cnt_q) - 3'd1))
    else $error("wrap count did not advance");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({7'd0, out_q.fused_angle} <= akf_pkg::FullTurn))
    else $error("fused angle beyond a full turn");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.out_load)
    else $error("output overwritten while stalled");

endmodule

@@ src/angle_kalman_fusion.sv @@
// A new sample is accepted only while idle, after the previous result has been loaded
// into the output register; each sample runs the two 31-step gain divisions, the shared
// multiplier, accumulator and angle wrap.
// A waiting result delays the next sample only while the output is stalled.
// Reset: asynchronous; restores the noise and period registers and the filter state.
`timescale 1ns / 1ps
module angle_kalman_fusion (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  akf_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output akf_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [akf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);

  akf_pkg::cmd_t    cmd;
  akf_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  akf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  akf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
